// ===== sv/frsr_pkg.sv =====
`timescale 1ns / 1ps
// frsr_pkg: constants, register indexes and sequencer states of the
// frame-rate scale regulator; no dependencies

package frsr_pkg;

  // window
  localparam int DEFAULT_WINDOW_DEPTH = 32;
  localparam int MIN_SAMPLES          = 10;

  // rate gaps in q8.8: 3 fps and 6 fps
  localparam int GAP_SMALL = 768;
  localparam int GAP_LARGE = 1536;

  // scale steps in 1/65536: about 0.001 and 0.002
  localparam int STEP_SMALL = 66;
  localparam int STEP_LARGE = 131;

  // scale clamp 0.4 .. 1.0 and write threshold of about 0.0005
  localparam int SCALE_MIN       = 26214;
  localparam int SCALE_MAX       = 65536;
  localparam int WRITE_THRESHOLD = 32;

  // target saturation 5 .. 30 fps in q8.8
  localparam int TARGET_MIN = 1280;
  localparam int TARGET_MAX = 7680;

  // register reset values
  localparam logic [12:0] TARGET_RESET   = 13'd7424;
  localparam logic [15:0] INTERVAL_RESET = 16'd5000;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ENABLE   = 2'd0,
    REG_TARGET   = 2'd1,
    REG_INTERVAL = 2'd2
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_EVAL,
    S_APPLY
  } state_e;

endpackage

// ===== sv/frame_rate_scale_regulator_unit.sv =====
`timescale 1ns / 1ps
// frame_rate_scale_regulator_unit: sample window in a synchronous ram, sum
// over the held entries, bit-serial average divide and scale step decision
// depends on frsr_pkg
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   in      | input     | in_valid_i / in_ready_o | rate_sample_i, time_ms_i, scale_now_i
//   out     | output    | out_valid_o/out_ready_i | scale_write_o, scale_next_o,
//           |           |                         | window_average_o
//   cfg     | input     | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// an enabled sample runs from transfer to result as one ram read per held
// entry, then one quotient bit per cycle over the SUM_W bit window sum,
// then decide and apply
// a disabled sample goes from idle straight to apply and leaves the window alone
// one sample is worked on at a time; in_ready_o is high only in idle
// the result register holds a result while the sink stalls; the next sample
// is taken meanwhile and waits in apply until the register frees
// reset clears control state only; the window ram needs no clearing because
// only held entries are ever read

module frame_rate_scale_regulator_unit
  import frsr_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // sample channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] rate_sample_i,
  input  logic [31:0] time_ms_i,
  input  logic [16:0] scale_now_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scale_write_o,
  output logic [16:0] scale_next_o,
  output logic [15:0] window_average_o
);

  localparam int ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = 16 + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W);

  localparam logic [CNT_W:0]     DepthWide  = (CNT_W + 1)'(WINDOW_DEPTH);
  localparam logic [CNT_W-1:0]   DepthCnt   = CNT_W'(WINDOW_DEPTH);
  localparam logic [CNT_W-1:0]   MinCnt     = CNT_W'(MIN_SAMPLES);
  localparam logic signed [17:0] GapSmall   = 18'(GAP_SMALL);
  localparam logic signed [17:0] GapLarge   = 18'(GAP_LARGE);
  localparam logic signed [8:0]  StepSmall  = 9'(STEP_SMALL);
  localparam logic signed [8:0]  StepLarge  = 9'(STEP_LARGE);
  localparam logic signed [18:0] ScaleMin   = 19'(SCALE_MIN);
  localparam logic signed [18:0] ScaleMax   = 19'(SCALE_MAX);
  localparam logic signed [18:0] WriteThr   = 19'(WRITE_THRESHOLD);
  localparam logic [12:0]        TargetMin  = 13'(TARGET_MIN);
  localparam logic [12:0]        TargetMax  = 13'(TARGET_MAX);

  // circular slot arithmetic: the slot stays below the depth, the offset at most the depth
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                 input logic [CNT_W-1:0]  b);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
    if (s >= DepthWide) begin
      s = s - DepthWide;
    end
    return s[ADDR_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  state_e state_q, state_d;

  logic              enable_q;
  logic [12:0]       target_q;
  logic [15:0]       interval_q;
  logic [CNT_W-1:0]  held_q;
  logic [ADDR_W-1:0] oldest_q;
  logic [31:0]       last_adjust_q;
  logic              pending_q;

  // latched sample
  logic [31:0] time_q;
  logic [16:0] scale_q;
  logic        en_item_q;

  // window sum
  logic [CNT_W-1:0]  idx_q;
  logic              rd_vld_q;
  logic [15:0]       rd_data_q;
  logic [SUM_W-1:0]  sum_q;

  // divider: quotient shifts in where the dividend shifts out
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q;
  logic [DCNT_W-1:0] div_cnt_q;

  // decision
  logic signed [8:0] step_q;
  logic              adjust_q;

  // result register
  logic        out_valid_q;
  logic        scale_write_q;
  logic [16:0] scale_next_q;
  logic [15:0] avg_out_q;

  // sample window ram
  logic [15:0] window_mem [WINDOW_DEPTH];

  // ---------------------------------------------------------------------
  // combinational datapath
  // ---------------------------------------------------------------------
  logic              accept;
  logic              apply_fire;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_issue;
  logic [12:0]       target_sat;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign apply_fire = (state_q == S_APPLY) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE);

  // append while filling, else overwrite the oldest entry
  assign wr_addr  = (held_q < DepthCnt) ? wrap_add(oldest_q, held_q) : oldest_q;
  assign rd_addr  = wrap_add(oldest_q, idx_q);
  assign rd_issue = (state_q == S_SUM) && (idx_q < held_q);

  always_comb begin
    target_sat = cfg_data_i[12:0];
    if (target_sat < TargetMin) begin
      target_sat = TargetMin;
    end else if (target_sat > TargetMax) begin
      target_sat = TargetMax;
    end
  end

  // restoring divide step
  logic [CNT_W:0]   div_trial;
  logic             div_bit;
  logic [CNT_W-1:0] div_rem;

  always_comb begin
    div_trial = {rem_q, quo_q[SUM_W-1]};
    div_bit   = (div_trial >= {1'b0, held_q});
    div_rem   = div_bit ? CNT_W'(div_trial - {1'b0, held_q}) : CNT_W'(div_trial);
  end

  // gap against target and step choice
  logic [15:0]       avg;
  logic [31:0]       elapsed;
  logic              time_ok;
  logic signed [17:0] gap;
  logic signed [8:0]  step_pick;

  assign avg     = quo_q[15:0];
  assign elapsed = time_q - last_adjust_q;
  assign time_ok = (elapsed >= {16'd0, interval_q});
  assign gap     = $signed({5'd0, target_q}) - $signed({2'd0, avg});

  always_comb begin
    step_pick = '0;
    if (gap > GapSmall) begin
      step_pick = (gap > GapLarge) ? -StepLarge : -StepSmall;
    end else if (gap < -GapSmall) begin
      step_pick = (gap < -GapLarge) ? StepLarge : StepSmall;
    end
  end

  // new scale, clamp and change test
  logic signed [18:0] ns_raw;
  logic signed [18:0] ns_clamp;
  logic signed [18:0] delta;
  logic               big_change;

  always_comb begin
    ns_raw   = $signed({2'b00, scale_q}) + {{10{step_q[8]}}, step_q};
    ns_clamp = ns_raw;
    if (ns_raw < ScaleMin) begin
      ns_clamp = ScaleMin;
    end else if (ns_raw > ScaleMax) begin
      ns_clamp = ScaleMax;
    end
    delta      = ns_clamp - $signed({2'b00, scale_q});
    big_change = (delta > WriteThr) || (delta < -WriteThr);
  end

  logic [CNT_W-1:0] drop;
  assign drop = held_q >> 1;

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = enable_q ? S_SUM : S_APPLY;
        end
      end
      S_SUM: begin
        // last read returned and accumulated
        if ((idx_q == held_q) && !rd_vld_q) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt_q == '0) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_APPLY;
      end
      S_APPLY: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // window ram: one write port, one registered read port
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept && enable_q) begin
      window_mem[wr_addr] <= rate_sample_i;
    end
    rd_data_q <= window_mem[rd_addr];
  end

  // ---------------------------------------------------------------------
  // control state and configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b0;
      target_q      <= TARGET_RESET;
      interval_q    <= INTERVAL_RESET;
      held_q        <= '0;
      oldest_q      <= '0;
      last_adjust_q <= '0;
      pending_q     <= 1'b1;
      idx_q         <= '0;
      rd_vld_q      <= 1'b0;
      div_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      rd_vld_q <= rd_issue;

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ENABLE: begin
            // turning on empties the window and rearms the timer
            if (cfg_data_i[0] && !enable_q) begin
              held_q    <= '0;
              oldest_q  <= '0;
              pending_q <= 1'b1;
            end
            enable_q <= cfg_data_i[0];
          end
          REG_TARGET: begin
            target_q <= target_sat;
          end
          REG_INTERVAL: begin
            interval_q <= cfg_data_i;
          end
          default: begin
          end
        endcase
      end else if (accept && enable_q) begin
        if (pending_q) begin
          last_adjust_q <= time_ms_i;
          pending_q     <= 1'b0;
        end
        if (held_q < DepthCnt) begin
          held_q <= held_q + CNT_W'(1);
        end else begin
          oldest_q <= wrap_add(oldest_q, CNT_W'(1));
        end
      end else if (apply_fire && en_item_q && adjust_q) begin
        // restart timer and, above the minimum count, drop the older half of the window
        last_adjust_q <= time_q;
        if (held_q > MinCnt) begin
          oldest_q <= wrap_add(oldest_q, drop);
          held_q   <= held_q - drop;
        end
      end

      if (accept) begin
        idx_q <= '0;
      end else if (rd_issue) begin
        idx_q <= idx_q + CNT_W'(1);
      end

      if (state_q == S_SUM) begin
        div_cnt_q <= DCNT_W'(SUM_W - 1);
      end else if (state_q == S_DIV) begin
        div_cnt_q <= div_cnt_q - DCNT_W'(1);
      end

      if (apply_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      time_q    <= time_ms_i;
      scale_q   <= scale_now_i;
      en_item_q <= enable_q;
      sum_q     <= '0;
    end else if (rd_vld_q) begin
      sum_q <= sum_q + SUM_W'(rd_data_q);
    end

    if (state_q == S_SUM) begin
      quo_q <= sum_q;
      rem_q <= '0;
    end else if (state_q == S_DIV) begin
      quo_q <= {quo_q[SUM_W-2:0], div_bit};
      rem_q <= div_rem;
    end

    if (state_q == S_EVAL) begin
      step_q   <= step_pick;
      adjust_q <= (held_q >= MinCnt) && time_ok && (step_pick != '0);
    end

    if (apply_fire) begin
      if (en_item_q && adjust_q && big_change) begin
        scale_write_q <= 1'b1;
        scale_next_q  <= ns_clamp[16:0];
      end else begin
        scale_write_q <= 1'b0;
        scale_next_q  <= '0;
      end
      avg_out_q <= en_item_q ? avg : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign scale_write_o    = scale_write_q;
  assign scale_next_o     = scale_next_q;
  assign window_average_o = avg_out_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_held_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= DepthCnt)
    else $error("held count beyond window depth");

  a_oldest_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q < ADDR_W'(WINDOW_DEPTH - 1) || oldest_q == ADDR_W'(WINDOW_DEPTH - 1))
    else $error("oldest slot beyond window depth");

  a_write_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scale_write_o |->
      scale_next_o >= 17'(SCALE_MIN) && scale_next_o <= 17'(SCALE_MAX))
    else $error("written scale outside clamp range");

  a_no_write_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !scale_write_o |-> scale_next_o == '0)
    else $error("scale_next not zero without a write");

  a_read_in_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == S_SUM && $past(state_q) == S_SUM)
    else $error("window read returned outside the sum phase");

endmodule

// ===== tb/tb_frame_rate_scale_regulator_unit.sv =====
`timescale 1ns / 1ps
// tb_frame_rate_scale_regulator_unit: self-checking bench for the frame-rate scale
// regulator, directed and random samples checked against a built-in window predictor
// depends on frsr_pkg and frame_rate_scale_regulator_unit

module tb_frame_rate_scale_regulator_unit;
  import frsr_pkg::*;

  localparam int DEPTH       = DEFAULT_WINDOW_DEPTH;
  localparam int LIVE_ITEMS  = 1200;      // enabled samples to send in total
  localparam int LONG_HOLD   = 600;       // sink hold-off that backs up the input
  localparam int TAIL_CYCLES = 100;       // idle tail after the final drain for stray results
  localparam int CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    logic [15:0] rate;
    logic [31:0] stamp;
    logic [16:0] scale;
  } rate_sample_t;

  typedef struct packed {
    logic        do_write;
    logic [16:0] scale;
    logic [15:0] average;
  } scale_result_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // block ports, all inputs known from time zero
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = REG_ENABLE;
  logic [15:0] cfg_data_i    = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [15:0] rate_sample_i = '0;
  logic [31:0] time_ms_i     = '0;
  logic [16:0] scale_now_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic        scale_write_o;
  logic [16:0] scale_next_o;
  logic [15:0] window_average_o;

  // predictor state: window, timer and register copies
  logic [15:0] win_store [DEPTH];
  int          win_held      = 0;
  int          win_oldest    = 0;
  logic [31:0] adj_stamp     = '0;
  bit          stamp_pending = 1'b1;
  bit          reg_enable    = 1'b0;
  logic [12:0] reg_target    = TARGET_RESET;
  logic [15:0] reg_interval  = INTERVAL_RESET;

  // samples waiting to be driven and results still owed by the block
  rate_sample_t  sample_queue [$];
  scale_result_t scale_results [$];

  int unsigned cycle_count = 0;
  int          fail_count  = 0;
  int          live_count  = 0;

  // traffic shaping
  bit steady       = 1'b0;   // no idling on either side
  bit hold_request = 1'b0;   // ask the sink for one long hold-off
  int idle_left    = 0;
  int stall_left   = 0;
  int hold_left    = 0;

  frame_rate_scale_regulator_unit #(
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rate_sample_i   (rate_sample_i),
    .time_ms_i       (time_ms_i),
    .scale_now_i     (scale_now_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .scale_write_o   (scale_write_o),
    .scale_next_o    (scale_next_o),
    .window_average_o(window_average_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones, none in steady phases
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [15:0] clip_rate(input int v);
    int c;
    c = v < 0 ? 0 : (v > 65535 ? 65535 : v);
    return c[15:0];
  endfunction

  // sample at a random distance from the target, spread over the step bands
  function automatic logic [15:0] rate_near();
    int mag;
    case ($urandom_range(0, 3))
      0:       mag = $urandom_range(0, GAP_SMALL);
      1:       mag = $urandom_range(GAP_SMALL + 1, GAP_LARGE);
      2:       mag = $urandom_range(GAP_LARGE + 1, 5000);
      default: mag = $urandom_range(5001, 65535);
    endcase
    if ($urandom_range(0, 1)) mag = -mag;
    return clip_rate(int'(reg_target) + mag);
  endfunction

  // constant-level offsets that sit on the dead band and step band edges
  function automatic int level_offset();
    case ($urandom_range(0, 12))
      0:  return 0;
      1:  return 512;
      2:  return -512;
      3:  return GAP_SMALL;
      4:  return -GAP_SMALL;
      5:  return GAP_SMALL + 1;
      6:  return -GAP_SMALL - 1;
      7:  return GAP_LARGE;
      8:  return -GAP_LARGE;
      9:  return GAP_LARGE + 1;
      10: return -GAP_LARGE - 1;
      11: return 3000;
      default: return -3000;
    endcase
  endfunction

  // scales on the clamp edges and the write threshold, and above 1.0
  function automatic logic [16:0] pick_scale();
    int v;
    case ($urandom_range(0, 10))
      0:  v = 0;
      1:  v = SCALE_MIN - 1;
      2:  v = SCALE_MIN;
      3:  v = SCALE_MIN + WRITE_THRESHOLD;
      4:  v = SCALE_MIN + WRITE_THRESHOLD + 1;
      5:  v = SCALE_MIN + STEP_SMALL;
      6:  v = SCALE_MAX - STEP_SMALL - WRITE_THRESHOLD - 1;
      7:  v = SCALE_MAX - STEP_SMALL;
      8:  v = SCALE_MAX;
      9:  v = 131071;
      default: v = $urandom_range(0, 131071);
    endcase
    return v[16:0];
  endfunction

  // window update, average and step decision for one accepted sample
  task automatic regulate_sample(input logic [15:0] rate, input logic [31:0] now,
                                 input logic [16:0] scale);
    scale_result_t res;
    int unsigned   sum;
    int unsigned   avg;
    logic [31:0]   elapsed;
    int            gap;
    int            step;
    int            ns;
    int            d;
    int            drop;
    res = '0;
    if (reg_enable) begin
      if (stamp_pending) begin
        adj_stamp     = now;
        stamp_pending = 1'b0;
      end
      // fill, or overwrite the oldest entry once the window is full
      if (win_held < DEPTH) begin
        win_store[(win_oldest + win_held) % DEPTH] = rate;
        win_held++;
      end else begin
        win_store[win_oldest] = rate;
        win_oldest = (win_oldest + 1) % DEPTH;
      end
      sum = 0;
      for (int i = 0; i < win_held; i++) sum += win_store[(win_oldest + i) % DEPTH];
      avg     = sum / win_held;
      elapsed = now - adj_stamp;  // wraps modulo 2^32
      step    = 0;
      if (win_held >= MIN_SAMPLES && elapsed >= {16'd0, reg_interval}) begin
        gap = int'(reg_target) - int'(avg);
        // within 3 fps nothing moves, not even the timer
        if (gap > GAP_SMALL) step = gap > GAP_LARGE ? -STEP_LARGE : -STEP_SMALL;
        else if (gap < -GAP_SMALL) step = gap < -GAP_LARGE ? STEP_LARGE : STEP_SMALL;
      end
      if (step != 0) begin
        ns = int'(scale) + step;
        if (ns < SCALE_MIN) ns = SCALE_MIN;
        if (ns > SCALE_MAX) ns = SCALE_MAX;
        d = ns - int'(scale);
        if (d > WRITE_THRESHOLD || d < -WRITE_THRESHOLD) begin
          res.do_write = 1'b1;
          res.scale    = ns[16:0];
        end
        // timer restarts, even on a small change; above MIN_SAMPLES the older half goes
        adj_stamp = now;
        if (win_held > MIN_SAMPLES) begin
          drop       = win_held / 2;
          win_oldest = (win_oldest + drop) % DEPTH;
          win_held  -= drop;
        end
      end
      res.average = avg[15:0];
    end
    scale_results.insert(scale_results.size(), res);
  endtask

  // one register write, mirrored into the predictor at the edge that takes it
  task automatic write_register(input cfg_reg_e idx, input logic [15:0] value);
    int t;
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ENABLE: begin
        // turning on empties the window and rearms the timer
        if (value[0] && !reg_enable) begin
          win_held      = 0;
          win_oldest    = 0;
          stamp_pending = 1'b1;
        end
        reg_enable = value[0];
      end
      REG_TARGET: begin
        t = int'(value & 16'h1FFF);
        if (t < TARGET_MIN) t = TARGET_MIN;
        if (t > TARGET_MAX) t = TARGET_MAX;
        reg_target = t[12:0];
      end
      REG_INTERVAL: reg_interval = value;
      default: ;
    endcase
  endtask

  task automatic queue_sample(input logic [15:0] rate, input logic [31:0] stamp,
                              input logic [16:0] scale);
    rate_sample_t entry;
    entry = '{rate: rate, stamp: stamp, scale: scale};
    sample_queue.insert(sample_queue.size(), entry);
    if (reg_enable) live_count++;
  endtask

  // sender pause: nothing left to drive and every result back
  task automatic drain();
    while (sample_queue.size() != 0 || scale_results.size() != 0 || in_valid_i)
      @(negedge clk_i);
  endtask

  // sample driver: holds valid and payload until the transfer, then may idle
  always @(posedge clk_i) begin : sample_driver
    rate_sample_t item;
    if (in_valid_i && in_ready_o)
      regulate_sample(rate_sample_i, time_ms_i, scale_now_i);
    if (!(in_valid_i && !in_ready_o)) begin
      if (idle_left > 0) begin
        idle_left--;
        in_valid_i <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        item          = sample_queue.pop_front();
        rate_sample_i <= item.rate;
        time_ms_i     <= item.stamp;
        scale_now_i   <= item.scale;
        in_valid_i    <= 1'b1;
        idle_left     = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor: checks each transfer against the oldest owed result and
  // shapes out_ready, including the one long hold-off
  always @(posedge clk_i) begin : result_monitor
    scale_result_t want;
    if (out_valid_o && out_ready_i) begin
      if (scale_results.size() == 0) begin
        $error("result with none owed: scale_write=%0d scale_next=%0d window_average=%0d",
               scale_write_o, scale_next_o, window_average_o);
        fail_count++;
      end else begin
        want = scale_results.pop_front();
        if (scale_write_o !== want.do_write) begin
          $error("scale_write: expected %0d, actual %0d", want.do_write, scale_write_o);
          fail_count++;
        end
        if (scale_next_o !== want.scale) begin
          $error("scale_next: expected %0d, actual %0d", want.scale, scale_next_o);
          fail_count++;
        end
        if (window_average_o !== want.average) begin
          $error("window_average: expected %0d, actual %0d", want.average, window_average_o);
          fail_count++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD;
      out_ready_i  <= 1'b0;
    end else if (steady) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      stall_left  = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_frame_rate_scale_regulator_unit: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] stamp;
    logic [15:0] word;
    logic [15:0] level;
    logic [16:0] scale;
    int          scale_walk;
    int          phase;
    int          n;
    int          kind;
    int          r;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // disabled after reset: samples are ignored, results all zero
    queue_sample(16'hFFFF, 32'hFFFF_FFFF, 17'h1FFFF);
    queue_sample(16'h0000, 32'h0000_0000, 17'h00000);
    drain();

    // zero interval, timer rearm just below the wrap, full-scale samples;
    // the tenth sample steps up from a scale above 1.0 and clamps to 1.0
    write_register(REG_INTERVAL, 16'h0000);
    write_register(REG_ENABLE, 16'h0001);
    for (int i = 0; i < 10; i++)
      queue_sample(16'hFFFF, 32'hFFFF_FFFB + i, i == 9 ? 17'h1FFFF : 17'(SCALE_MAX));
    drain();

    // re-enable clears the window; low target saturates to 5 fps; silent
    // samples step down into the lower clamp, a small change with no write
    write_register(REG_ENABLE, 16'h0000);
    write_register(REG_ENABLE, 16'h0001);
    write_register(REG_TARGET, 16'h0000);
    for (int i = 0; i < 10; i++)
      queue_sample(16'h0000, 32'd100 + i, 17'(SCALE_MIN));
    drain();

    // enable again while on changes nothing; eleventh sample writes and trims
    write_register(REG_ENABLE, 16'hFFFF);
    queue_sample(16'h0000, 32'd200, 17'd0);
    drain();

    // random phases: each one reprograms some registers while idle and then
    // sends a sequence of samples with a running timestamp
    stamp      = $urandom;
    scale_walk = $urandom_range(SCALE_MIN, SCALE_MAX);
    phase      = 0;
    while (live_count < LIVE_ITEMS) begin
      drain();
      steady = ($urandom_range(0, 5) == 0);
      if (phase == 3) hold_request = 1'b1;

      r = $urandom_range(0, 9);
      if (r < 7) begin
        word    = 16'($urandom);
        word[0] = 1'b1;
        write_register(REG_ENABLE, word);
      end else if (r == 7) begin
        word    = 16'($urandom);
        word[0] = 1'b0;
        write_register(REG_ENABLE, word);
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 7))
          0:       word = 16'h0000;
          1:       word = 16'hFFFF;
          2:       word = 16'(TARGET_MIN);
          3:       word = 16'(TARGET_MAX);
          4:       word = 16'h1FFF;
          5:       word = 16'($urandom);
          default: word = 16'($urandom_range(TARGET_MIN, TARGET_MAX));
        endcase
        write_register(REG_TARGET, word);
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       word = 16'h0000;
          1:       word = 16'h0001;
          2:       word = 16'hFFFF;
          3:       word = 16'($urandom);
          default: word = 16'($urandom_range(0, 300));
        endcase
        write_register(REG_INTERVAL, word);
      end
      @(negedge clk_i);

      // kinds: constant level, spread around the target, slow clock, noise
      n     = reg_enable ? $urandom_range(10, 60) : $urandom_range(2, 8);
      kind  = $urandom_range(0, 9);
      level = clip_rate(int'(reg_target) + level_offset());
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 4) stamp = $urandom;
        else if (r < 8) stamp = stamp;
        else if (kind == 8) stamp += $urandom_range(0, 1);
        else stamp += $urandom_range(0, int'(reg_interval) / 4 + 3);

        scale_walk += $urandom_range(0, 400) - 200;
        if (scale_walk < 0) scale_walk = 0;
        if (scale_walk > SCALE_MAX) scale_walk = SCALE_MAX;
        scale = ($urandom_range(0, 7) == 0) ? pick_scale() : scale_walk[16:0];

        if (kind < 3) queue_sample(level, stamp, scale);
        else if (kind < 9) queue_sample(rate_near(), stamp, scale);
        else queue_sample(16'($urandom), stamp, scale);
      end
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (scale_results.size() != 0) begin
      $error("%0d results never arrived", scale_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_frame_rate_scale_regulator_unit: PASS");
    end else begin
      $display("tb_frame_rate_scale_regulator_unit: FAIL");
    end
    $finish;
  end

endmodule

// ===== frame_rate_scale_regulator_unit.f =====
sv/frsr_pkg.sv
sv/frame_rate_scale_regulator_unit.sv
tb/tb_frame_rate_scale_regulator_unit.sv
